>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)

`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)

`endif

`endif

>>> rtl/ffva_pkg.sv
`timescale 1ns / 1ps

package ffva_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // word index of each configuration register
  localparam logic REG_CHANNEL_LIMIT = 1'b0;

  localparam logic [4:0] CHANNEL_LIMIT_RST = 5'd16;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_SCAN = 3'd1;
  localparam step_t ST_CMP  = 3'd2;
  localparam step_t ST_OPEN = 3'd3;
  localparam step_t ST_FIT  = 3'd4;
  localparam step_t ST_OUT  = 3'd5;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN_ACC   = 3'd1,
    COND_IDX_END  = 3'd2,
    COND_FIT      = 3'd3,
    COND_OUT_FREE = 3'd4
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  rd_issue;
    logic  inc_on_miss;
    logic  do_open;
    logic  do_fit;
    logic  do_out;
    cond_t cond;
    step_t jt;
    step_t jf;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t c;
    c = '0;
    c.cond = COND_ALWAYS;
    c.jt   = ST_IDLE;
    c.jf   = ST_IDLE;
    unique case (step)
      ST_IDLE: begin
        c.in_rdy = 1'b1;
        c.cond   = COND_IN_ACC;
        c.jt     = ST_SCAN;
        c.jf     = ST_IDLE;
      end
      ST_SCAN: begin
        c.rd_issue = 1'b1;
        c.cond     = COND_IDX_END;
        c.jt       = ST_OPEN;
        c.jf       = ST_CMP;
      end
      ST_CMP: begin
        c.inc_on_miss = 1'b1;
        c.cond        = COND_FIT;
        c.jt          = ST_FIT;
        c.jf          = ST_SCAN;
      end
      ST_OPEN: begin
        c.do_open = 1'b1;
        c.jt      = ST_OUT;
        c.jf      = ST_OUT;
      end
      ST_FIT: begin
        c.do_fit = 1'b1;
        c.jt     = ST_OUT;
        c.jf     = ST_OUT;
      end
      ST_OUT: begin
        c.do_out = 1'b1;
        c.cond   = COND_OUT_FREE;
        c.jt     = ST_IDLE;
        c.jf     = ST_OUT;
      end
      default: begin
        c.jt = ST_IDLE;
        c.jf = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ffva_ram.sv
`timescale 1ns / 1ps

module ffva_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/first_fit_voice_allocator.sv
`timescale 1ns / 1ps
// First-fit voice allocator. Each note request is placed on the lowest open
// channel whose end time is at or before the note's start; if none fits, a new
// channel is opened while the count stays under channel_limit (capped at
// MAX_CHANNELS), else the note comes back flagged rejected with state left as
// it was. A small microcode sequencer scans the channel end times kept in a
// RAM with one write and one read port, each channel inspected in turn (read,
// then compare). A new request is taken once the previous result has moved
// into the output register, so the output may hold one result while the next
// request is worked on.
// End times need no clearing after reset: a channel is written when opened.

`include "assert_macros.svh"

module first_fit_voice_allocator #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ffva_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [ffva_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [ffva_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [6:0]                       pitch,
  input  logic [6:0]                       velocity,
  input  logic [31:0]                      start_time,
  input  logic [31:0]                      duration,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       channel,
  output logic [31:0]                      rest_gap,
  output logic [6:0]                       pitch_out,
  output logic [6:0]                       velocity_out,
  output logic [31:0]                      duration_out,
  output logic                             opened_channel,
  output logic                             rejected
);

  import ffva_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [4:0]           channel_limit;
  step_t                step;
  step_t                step_next;
  ctrl_t                ctrl;
  logic                 cond_hit;
  logic [CNT_W-1:0]     open_cnt;
  logic [CNT_W-1:0]     idx;
  logic [6:0]           pitch_q;
  logic [6:0]           velocity_q;
  logic [31:0]          start_q;
  logic [31:0]          duration_q;
  logic [3:0]           res_channel;
  logic [31:0]          res_gap;
  logic                 res_opened;
  logic                 res_rejected;
  logic [TIME_BITS-1:0] start_t;
  logic [TIME_BITS-1:0] dur_t;
  logic [TIME_BITS:0]   end_sum;
  logic [TIME_BITS-1:0] end_sat;
  logic [TIME_BITS-1:0] rdata;
  logic [7:0]           limit_eff;
  logic                 can_open;
  logic                 in_acc;
  logic                 out_free;
  logic                 cfg_wr;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHANNEL_LIMIT);
  assign prdata = (paddr[2] == REG_CHANNEL_LIMIT) ? CFG_DATA_W'(channel_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_limit <= CHANNEL_LIMIT_RST;
    end else if (cfg_wr) begin
      channel_limit <= pwdata[4:0];
    end
  end

  // sequencer
  assign ctrl     = ucode_rom(step);
  assign in_ready = ctrl.in_rdy;
  assign in_acc   = in_valid && ctrl.in_rdy;
  assign out_free = !out_valid || out_ready;

  assign start_t   = TIME_BITS'(start_q);
  assign dur_t     = TIME_BITS'(duration_q);
  assign end_sum   = {1'b0, start_t} + {1'b0, dur_t};
  assign end_sat   = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
  assign limit_eff = (8'(channel_limit) > 8'(MAX_CHANNELS)) ? 8'(MAX_CHANNELS)
                                                           : 8'(channel_limit);
  assign can_open  = 8'(open_cnt) < limit_eff;

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_IN_ACC:   cond_hit = in_valid;
      COND_IDX_END:  cond_hit = idx >= open_cnt;
      COND_FIT:      cond_hit = rdata <= start_t;
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? ctrl.jt : ctrl.jf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= ST_IDLE;
      open_cnt <= '0;
      idx      <= '0;
    end else begin
      step <= step_next;
      if (in_acc) begin
        idx <= '0;
      end else if (ctrl.inc_on_miss && !cond_hit) begin
        idx <= idx + 1'b1;
      end
      if (ctrl.do_open && can_open) begin
        open_cnt <= open_cnt + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pitch_q    <= pitch;
      velocity_q <= velocity;
      start_q    <= start_time;
      duration_q <= duration;
    end
    if (ctrl.do_open) begin
      res_opened   <= can_open;
      res_rejected <= !can_open;
      res_channel  <= can_open ? 4'(open_cnt) : 4'd0;
      res_gap      <= can_open ? 32'(start_t) : 32'd0;
    end
    if (ctrl.do_fit) begin
      res_opened   <= 1'b0;
      res_rejected <= 1'b0;
      res_channel  <= 4'(idx);
      res_gap      <= 32'(start_t - rdata);
    end
  end

  assign ram_we    = ctrl.do_fit || (ctrl.do_open && can_open);
  assign ram_waddr = ctrl.do_fit ? idx[AW-1:0] : open_cnt[AW-1:0];

  ffva_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_CHANNELS)
  ) u_end_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (end_sat),
    .re    (ctrl.rd_issue),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.do_out && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.do_out && out_free) begin
      channel        <= res_channel;
      rest_gap       <= res_gap;
      pitch_out      <= pitch_q;
      velocity_out   <= velocity_q;
      duration_out   <= duration_q;
      opened_channel <= res_opened;
      rejected       <= res_rejected;
    end
  end

  `ASSERT_IMPLY(a_open_cap, clk, rst, 1'b1, open_cnt <= CNT_W'(MAX_CHANNELS), "open count over max")
  `ASSERT_IMPLY(a_fit_in_range, clk, rst, step == ST_FIT, idx < open_cnt, "fit on unopened channel")
  `ASSERT_NEXT(a_open_incr, clk, rst, ctrl.do_open && can_open, open_cnt == $past(open_cnt) + 1'b1, "open count not advanced")
  `ASSERT_IMPLY(a_reject_clean, clk, rst, out_valid && rejected, !opened_channel && channel == 4'd0 && rest_gap == 32'd0, "rejected result not clean")

endmodule

>>> dv/tb_first_fit_voice_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_voice_allocator;
  import ffva_pkg::*;

  localparam int unsigned NUM_CH       = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * NUM_CH + 8;
  localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * REG_CHANNEL_LIMIT);
  localparam logic [4:0] SEQ_LIMITS [8] = '{5'd4, 5'd8, 5'd2, 5'd16,
                                            5'd31, 5'd0, 5'd17, 5'd16};

  typedef struct packed {
    logic [3:0]  chan;
    logic [31:0] gap;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [31:0] dur;
    logic        opened;
    logic        dropped;
  } voice_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [6:0]            pitch = '0;
  logic [6:0]            velocity = '0;
  logic [31:0]           start_time = '0;
  logic [31:0]           duration = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [3:0]            channel;
  logic [31:0]           rest_gap;
  logic [6:0]            pitch_out;
  logic [6:0]            velocity_out;
  logic [31:0]           duration_out;
  logic                  opened_channel;
  logic                  rejected;

  // predicted allocator state
  logic [31:0] chan_end [NUM_CH];
  int unsigned chans_open = 0;
  logic [4:0]  limit_reg = CHANNEL_LIMIT_RST;

  voice_t      pending[$];
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  logic [31:0] cursor = 32'd1000;

  first_fit_voice_allocator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic voice_t place_note(input logic [6:0] p, input logic [6:0] v,
                                        input logic [31:0] t0, input logic [31:0] len);
    voice_t      r;
    int unsigned cap;
    int unsigned k;
    logic [32:0] fin;
    bit          hit;
    r = '0;
    r.pitch = p;
    r.velocity = v;
    r.dur = len;
    cap = (limit_reg > NUM_CH) ? NUM_CH : limit_reg;
    hit = 1'b0;
    k = 0;
    for (int i = 0; i < chans_open; i++) begin
      if (!hit && chan_end[i] <= t0) begin
        hit = 1'b1;
        k = i;
      end
    end
    if (!hit && chans_open < cap) begin
      hit = 1'b1;
      k = chans_open;
      chan_end[k] = '0;
      chans_open++;
      r.opened = 1'b1;
    end
    if (hit) begin
      r.chan = k[3:0];
      r.gap = t0 - chan_end[k];
      fin = {1'b0, t0} + {1'b0, len};
      chan_end[k] = fin[32] ? '1 : fin[31:0];
    end else begin
      r.dropped = 1'b1;
    end
    return r;
  endfunction

  task automatic send_note(input logic [6:0] p, input logic [6:0] v,
                           input logic [31:0] t0, input logic [31:0] len);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pitch <= p;
    velocity <= v;
    start_time <= t0;
    duration <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.insert(pending.size(), place_note(p, v, t0, len));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] lim);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= CFG_DATA_W'(lim);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = lim;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("channel_limit", 32'(lim), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // notes in time order with random spacing; some arrive late
  task automatic send_phrase(input int unsigned count, input int unsigned step_max,
                             input int unsigned len_max);
    logic [31:0] t0;
    logic [31:0] len;
    repeat (count) begin
      if ($urandom_range(99) < 12) begin
        t0 = cursor - $urandom_range(0, 600);
        len = $urandom_range(0, 4 * len_max);
      end else begin
        t0 = cursor;
        len = ($urandom_range(19) == 0) ? 32'd0 : $urandom_range(1, len_max);
        cursor = cursor + $urandom_range(0, step_max);
        if ($urandom_range(49) == 0) cursor = cursor + $urandom_range(0, 1 << 18);
      end
      send_note(7'($urandom_range(127)), 7'($urandom_range(127)), t0, len);
    end
  endtask

  task automatic test_directed;
    write_limit(5'd1);
    send_note(7'd0,   7'd127, 32'd100, 32'd50);
    send_note(7'd127, 7'd0,   32'd120, 32'd10);
    send_note(7'd64,  7'd1,   32'd150, 32'd0);
    send_note(7'd1,   7'd126, 32'd149, 32'd5);
    drain;
    write_limit(5'd0);
    send_note(7'd85,  7'd42,  32'd140, 32'd1);
    send_note(7'd42,  7'd85,  32'd200, 32'd10);
    drain;
    write_limit(5'd31);
    send_note(7'd127, 7'd127, 32'd205, 32'd5);
    send_note(7'd0,   7'd0,   32'd0,   32'd0);
    send_note(7'd3,   7'd3,   32'd0,   32'hFFFF_FFFF);
    send_note(7'd5,   7'd9,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_note(7'd9,   7'd5,   32'hFFFF_FFFF, 32'd0);
    drain;
    write_limit(5'd2);
    send_note(7'd10,  7'd20,  32'd5,   32'd1);
    send_note(7'd20,  7'd10,  32'd210, 32'd10);
    drain;
    write_limit(5'd17);
    send_note(7'd33,  7'd66,  32'd215, 32'd5);
  endtask

  task automatic test_back_pressure;
    drain;
    write_limit(5'd16);
    hold_left = 300;
    send_phrase(20, 8, 100);
    drain;
    send_phrase(10, 8, 100);
  endtask

  task automatic test_sequences;
    foreach (SEQ_LIMITS[s]) begin
      drain;
      write_limit(SEQ_LIMITS[s]);
      calm = (s == 2);
      repeat (4) begin
        case ($urandom_range(2))
          0: send_phrase(42, 1, 300);
          1: send_phrase(42, 8, 300);
          default: send_phrase(42, 40, 300);
        endcase
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_noise;
    drain;
    write_limit(5'd16);
    repeat (140) send_note(7'($urandom_range(127)), 7'($urandom_range(127)),
                           $urandom, $urandom);
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h, actual %0h", $time, what, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin : check_results
    voice_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual channel %0d",
                 $time, channel);
        fail_count++;
      end else begin
        want = pending.pop_front();
        check_field("channel", 32'(want.chan), 32'(channel));
        check_field("rest_gap", want.gap, rest_gap);
        check_field("pitch_out", 32'(want.pitch), 32'(pitch_out));
        check_field("velocity_out", 32'(want.velocity), 32'(velocity_out));
        check_field("duration_out", want.dur, duration_out);
        check_field("opened_channel", 32'(want.opened), 32'(opened_channel));
        check_field("rejected", 32'(want.dropped), 32'(rejected));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("first_fit_voice_allocator: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_CH; i++) chan_end[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed;
    test_back_pressure;
    test_sequences;
    test_noise;
    drain;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("first_fit_voice_allocator: match");
    end else begin
      $display("first_fit_voice_allocator: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ffva_pkg.sv
rtl/ffva_ram.sv
rtl/first_fit_voice_allocator.sv
dv/tb_first_fit_voice_allocator.sv
